>>> rtl/core/masked_byte_signature_scan_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the masked byte signature scanner
// Shared property wrappers clocked on clk_i with reset taken into account.
// ----------------------------------------------------------------------------
`ifndef MASKED_BYTE_SIGNATURE_SCAN_MACROS_SVH
`define MASKED_BYTE_SIGNATURE_SCAN_MACROS_SVH

// Checks an implication on every rising clock edge outside reset.
`define MBSS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks an implication on every rising clock edge, reset included.
`define MBSS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/core/mbss_pkg.sv
// ----------------------------------------------------------------------------
// Masked byte signature scanner package
// Sizes, register indexes and the types passed between the scanner stages.
// ----------------------------------------------------------------------------
package mbss_pkg;

  localparam int MaxPatternBytes = 16;
  localparam int RegBytes        = 16;
  localparam int OffsetBits      = 32;
  localparam int MatchBits       = 32;
  localparam int LenBits         = $clog2(MaxPatternBytes + 1);
  localparam int IdxBits         = (MaxPatternBytes > 1) ? $clog2(MaxPatternBytes) : 1;
  localparam int CfgIndexBits    = 3;
  localparam int CfgDataBits     = 64;

  typedef enum logic [CfgIndexBits-1:0] {
    RegPatternLow  = 3'd0,
    RegPatternHigh = 3'd1,
    RegMaskLow     = 3'd2,
    RegMaskHigh    = 3'd3,
    RegPatternLen  = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [RegBytes-1:0][7:0] pattern;
    logic [RegBytes-1:0][7:0] mask;
    logic [LenBits-1:0]       length;
  } cfg_t;

  typedef struct packed {
    logic                            valid;
    logic [LenBits-1:0]              fill;
    logic [OffsetBits-1:0]           here;
    logic [MaxPatternBytes-1:0][7:0] bytes;
  } window_t;

endpackage

>>> rtl/core/mbss_cfg.sv
// ----------------------------------------------------------------------------
// Scanner configuration registers
// Holds pattern, mask and length, and presents the clamped active length.
// ----------------------------------------------------------------------------
module mbss_cfg
  import mbss_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CfgIndexBits-1:0] cfg_index_i,
  input  logic [CfgDataBits-1:0]  cfg_data_i,
  output cfg_t                    cfg_o
);

  logic [CfgDataBits-1:0] pat_lo_q, pat_hi_q, mask_lo_q, mask_hi_q;
  logic [4:0]             len_q;
  logic [LenBits-1:0]     len_active;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q  <= '0;
      pat_hi_q  <= '0;
      mask_lo_q <= '0;
      mask_hi_q <= '0;
      len_q     <= 5'd1;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        RegPatternLow:  pat_lo_q  <= cfg_data_i;
        RegPatternHigh: pat_hi_q  <= cfg_data_i;
        RegMaskLow:     mask_lo_q <= cfg_data_i;
        RegMaskHigh:    mask_hi_q <= cfg_data_i;
        RegPatternLen:  len_q     <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // A length of zero acts as one; anything past the window depth saturates.
  always_comb begin
    if (len_q == 5'd0) begin
      len_active = LenBits'(1);
    end else if (32'(len_q) > MaxPatternBytes) begin
      len_active = LenBits'(MaxPatternBytes);
    end else begin
      len_active = LenBits'(len_q);
    end
  end

  assign cfg_o.pattern = {pat_hi_q, pat_lo_q};
  assign cfg_o.mask    = {mask_hi_q, mask_lo_q};
  assign cfg_o.length  = len_active;

endmodule

>>> rtl/core/mbss_window.sv
// ----------------------------------------------------------------------------
// Scanner input stage
// Takes one byte per transaction into the sliding window and tracks offsets.
// ----------------------------------------------------------------------------
module mbss_window
  import mbss_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic    section_start_i,
  input  logic    advance_i,
  output window_t win_o
);

  logic                            valid_q, valid_d;
  logic [LenBits-1:0]              fill_q, fill_d;
  logic [OffsetBits-1:0]           here_q, here_d;
  logic [OffsetBits-1:0]           pos_q, pos_d;
  logic [MaxPatternBytes-1:0][7:0] bytes_q, bytes_d;
  logic                            accept;

  assign in_ready_o = !valid_q || advance_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    fill_d  = fill_q;
    here_d  = here_q;
    pos_d   = pos_q;
    bytes_d = bytes_q;
    if (advance_i) begin
      valid_d = 1'b0;
    end
    if (accept) begin
      valid_d = 1'b1;
      if (section_start_i) begin
        bytes_d    = '0;
        bytes_d[0] = data_byte_i;
        fill_d     = LenBits'(1);
        here_d     = '0;
        pos_d      = OffsetBits'(1);
      end else begin
        bytes_d = {bytes_q[MaxPatternBytes-2:0], data_byte_i};
        if (32'(fill_q) < MaxPatternBytes) begin
          fill_d = fill_q + LenBits'(1);
        end
        here_d = pos_q;
        pos_d  = pos_q + OffsetBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      fill_q  <= '0;
      here_q  <= '0;
      pos_q   <= '0;
      bytes_q <= '0;
    end else begin
      valid_q <= valid_d;
      fill_q  <= fill_d;
      here_q  <= here_d;
      pos_q   <= pos_d;
      bytes_q <= bytes_d;
    end
  end

  assign win_o.valid = valid_q;
  assign win_o.fill  = fill_q;
  assign win_o.here  = here_q;
  assign win_o.bytes = bytes_q;

endmodule

>>> rtl/core/mbss_match.sv
// ----------------------------------------------------------------------------
// Scanner compare and result stage
// Compares the window against the masked pattern and registers the offset.
// ----------------------------------------------------------------------------
module mbss_match
  import mbss_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  window_t              win_i,
  input  cfg_t                 cfg_i,
  output logic                 advance_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [MatchBits-1:0] match_offset_o
);

  logic [MaxPatternBytes-1:0] lane_ok;
  logic [LenBits-1:0]         sel [MaxPatternBytes];
  logic                       hit;
  logic [OffsetBits-1:0]      start_off;
  logic                       valid_q;
  logic [MatchBits-1:0]       offset_q;

  // Pattern byte j lines up with the byte taken in length-1-j transactions ago.
  always_comb begin
    for (int j = 0; j < MaxPatternBytes; j++) begin
      sel[j]     = cfg_i.length - LenBits'(1) - LenBits'(j);
      lane_ok[j] = 1'b1;
      if (LenBits'(j) < cfg_i.length) begin
        lane_ok[j] = ((win_i.bytes[sel[j][IdxBits-1:0]] & cfg_i.mask[j])
                      == (cfg_i.pattern[j] & cfg_i.mask[j]));
      end
    end
  end

  assign hit       = win_i.valid && (win_i.fill >= cfg_i.length) && (&lane_ok);
  assign start_off = win_i.here - OffsetBits'(cfg_i.length - LenBits'(1));
  assign advance_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && hit) begin
      offset_q <= MatchBits'(start_off);
    end
  end

  assign out_valid_o    = valid_q;
  assign match_offset_o = offset_q;

endmodule

>>> rtl/core/masked_byte_signature_scan.sv
// ----------------------------------------------------------------------------
// Masked byte signature scanner
// Searches a byte stream for a masked signature of up to 16 bytes.
// ----------------------------------------------------------------------------
// The slave stream carries one section byte per transaction in tdata, and
// tuser marks the first byte of a new section, which restarts the offset at
// zero and empties the window. The master stream carries the section offset
// where a matching window begins. Bytes that complete no match produce no
// transaction on the master side.
// A byte is taken every cycle unless the receiver stalls. A match passes
// through the input window register and then the result register, around
// the parallel masked compare, before it appears on the master side.
// When the receiver stalls, the result register holds its offset and the
// window register can still take one more byte; then tready drops.
// After reset the window is empty, the pattern and mask are zero and the
// length is one. Configuration writes are always ready; the user must make
// them only while no byte is in flight, as the block does not enforce this.
// ----------------------------------------------------------------------------
module masked_byte_signature_scan
  import mbss_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [7:0]              s_axis_tdata,   // [7:0] data_byte
  input  logic                    s_axis_tuser,   // [0] section_start
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [MatchBits-1:0]    m_axis_tdata,   // [31:0] match_offset
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CfgIndexBits-1:0] cfg_index_i,
  input  logic [CfgDataBits-1:0]  cfg_data_i
);

  cfg_t    cfg;
  window_t win;
  logic    advance;

  mbss_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  mbss_window u_window (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .data_byte_i     (s_axis_tdata),
    .section_start_i (s_axis_tuser),
    .advance_i       (advance),
    .win_o           (win)
  );

  mbss_match u_match (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .win_i          (win),
    .cfg_i          (cfg),
    .advance_o      (advance),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .match_offset_o (m_axis_tdata)
  );

endmodule

>>> rtl/core/mbss_checker.sv
// ----------------------------------------------------------------------------
// Masked byte signature scanner port checker
// Watches the stream ports of the scanner for handshake and flow errors.
// ----------------------------------------------------------------------------
`include "masked_byte_signature_scan_macros.svh"

module mbss_checker
  import mbss_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [MatchBits-1:0] m_axis_tdata
);

  logic out_stall;
  logic in_take;
  logic slot_used_q;

  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign in_take   = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_used_q <= 1'b0;
    end else begin
      slot_used_q <= out_stall && in_take;
    end
  end

  `MBSS_ASSERT(a_out_valid_held, out_stall |=> m_axis_tvalid, "result dropped while stalled")
  `MBSS_ASSERT(a_out_data_held, out_stall |=> $stable(m_axis_tdata), "result data changed")
  `MBSS_ASSERT(a_ready_only_on_stall, !s_axis_tready |-> out_stall, "input blocked")
  `MBSS_ASSERT(a_one_slot_on_stall, (out_stall && slot_used_q) |-> !s_axis_tready, "extra byte")
  `MBSS_ASSERT_ALWAYS(a_no_result_in_reset, !rst_ni |-> !m_axis_tvalid, "result in reset")

endmodule

bind masked_byte_signature_scan mbss_checker u_mbss_checker (.*);
